// ===== design/partition_fit_allocator_top_assert.svh =====
// Assertion macros used by the checker file of the partition allocator.
`ifndef PARTITION_FIT_ALLOCATOR_TOP_ASSERT_SVH
`define PARTITION_FIT_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("partition allocator check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("partition allocator check failed");

`endif

// ===== design/pfa_pkg.sv =====
package pfa_pkg;

  // Table geometry.
  localparam int PARTITIONS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(PARTITIONS);
  localparam int CNT_W      = $clog2(PARTITIONS + 1);

  // Command codes.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Placement policies; the unused code behaves as worst fit.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_FIT_POLICY = 1'b0;
  localparam logic CFG_PARTITIONS = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  // Control from the sequencer to the fit unit.
  typedef struct packed {
    logic             clear;
    logic             step;
    logic [IDX_W-1:0] idx;
  } fit_ctl_t;

  // Running choice held by the fit unit.
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] best;
  } fit_stat_t;

endpackage

// ===== design/pfa_fit_unit.sv =====
module pfa_fit_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pfa_pkg::fit_ctl_t              ctl_i,
  input  logic [1:0]                     policy_i,
  input  logic [15:0]                    req_i,
  input  logic [pfa_pkg::SIZE_BITS-1:0]  entry_i,
  output pfa_pkg::fit_stat_t             stat_o
);
  import pfa_pkg::*;

  logic                 found_q;
  logic [IDX_W-1:0]     pick_q;
  logic [SIZE_BITS-1:0] best_q;
  logic                 fits;
  logic                 better;
  logic                 take;

  // The entry fits when it holds at least the request. Comparing free sizes
  // is the same as comparing leftovers, since the request is common.
  assign fits = 32'(entry_i) >= 32'(req_i);

  always_comb begin
    case (policy_i)
      POL_FIRST: better = 1'b0;
      POL_BEST:  better = entry_i < best_q;
      default:   better = entry_i > best_q;
    endcase
  end

  assign take = ctl_i.step && fits && (!found_q || better);

  // Found flag of the running choice.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  // Index and free size of the running choice.
  always_ff @(posedge clk_i) begin
    if (take) begin
      pick_q <= ctl_i.idx;
      best_q <= entry_i;
    end
  end

  assign stat_o.found = found_q;
  assign stat_o.pick  = pick_q;
  assign stat_o.best  = best_q;

endmodule

// ===== design/partition_fit_allocator_top.sv =====
// Partition fit allocator. A table of 16 partition free sizes is kept in a
// small memory with one write port and one registered read port. A load
// writes an entry and returns its value, a read returns an entry, and an
// allocate places its request by first, best or worst fit and returns the
// one-based partition number and the space left there (0 when nothing fits).
// Each item gives one result beat. The block takes one item at a time: a
// load or an unknown command goes straight to the emit step, a read passes
// through a read step first, and an allocate through a scan step over n
// partitions (up to 16) and an update step, because the shared fit unit
// compares one table entry per cycle as the read port sweeps the table.
// Entries must be loaded before they are read or searched. A stall on the
// output holds the block in its final step until the beat can be taken.
module partition_fit_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  slot_i,
  input  logic [15:0] amount_i,
  input  logic        final_request_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        placed_o,
  output logic [4:0]  slot_number_o,
  output logic [15:0] free_left_o,
  output logic        batch_done_o
);
  import pfa_pkg::*;

  state_e               state_q, state_d;
  logic [1:0]           policy_q;
  logic [4:0]           parts_q;
  logic [15:0]          amount_q;
  logic                 fin_q;
  logic [IDX_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     n_search;
  logic                 slot_ok;
  logic                 in_acc;
  logic                 last_step;
  logic                 out_free;
  logic                 out_load;

  logic [SIZE_BITS-1:0] mem_q [PARTITIONS];
  logic [SIZE_BITS-1:0] rd_data_q;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]     rd_addr;

  logic                 res_placed_q;
  logic [4:0]           res_number_q;
  logic [15:0]          res_free_q;

  logic                 out_valid_q;
  logic                 out_placed_q;
  logic [4:0]           out_number_q;
  logic [15:0]          out_free_q;
  logic                 out_fin_q;

  fit_ctl_t             fit_ctl;
  fit_stat_t            fit_stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIRST;
      parts_q  <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FIT_POLICY: policy_q <= cfg_wdata_i[1:0];
        CFG_PARTITIONS: parts_q  <= cfg_wdata_i;
        default:        parts_q  <= parts_q;
      endcase
    end
  end

  // Number of partitions searched, capped at the table depth.
  assign n_search  = (32'(parts_q) > 32'(PARTITIONS)) ? CNT_W'(PARTITIONS)
                                                      : CNT_W'(parts_q);
  assign slot_ok   = 32'(slot_i) < 32'(PARTITIONS);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign last_step = (CNT_W'(cnt_q) + CNT_W'(1)) == n_search;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_i)
            CMD_LOAD:  state_d = ST_EMIT;
            CMD_ALLOC: state_d = (n_search == '0) ? ST_EMIT : ST_SCAN;
            CMD_READ:  state_d = slot_ok ? ST_READ : ST_EMIT;
            default:   state_d = ST_EMIT;
          endcase
        end
      end
      ST_SCAN:   state_d = last_step ? ST_UPDATE : ST_SCAN;
      ST_READ:   state_d = ST_EMIT;
      ST_UPDATE: state_d = ST_EMIT;
      ST_EMIT:   state_d = out_free ? ST_IDLE : ST_EMIT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Output logic of the sequencer: table ports, fit unit control, handshakes.
  always_comb begin
    in_stall_o  = state_q != ST_IDLE;
    mem_we      = 1'b0;
    mem_waddr   = IDX_W'(slot_i);
    mem_wdata   = SIZE_BITS'(amount_i);
    rd_addr     = cnt_q + IDX_W'(1);
    fit_ctl     = '0;
    fit_ctl.idx = cnt_q;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        mem_we        = in_acc && (cmd_i == CMD_LOAD) && slot_ok;
        rd_addr       = (cmd_i == CMD_READ) ? IDX_W'(slot_i) : '0;
        fit_ctl.clear = in_acc;
      end
      ST_SCAN: begin
        fit_ctl.step = 1'b1;
      end
      ST_UPDATE: begin
        mem_we    = fit_stat.found;
        mem_waddr = fit_stat.pick;
        mem_wdata = fit_stat.best - SIZE_BITS'(amount_q);
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Scan counter: entry under test in the fit unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == ST_IDLE) begin
      cnt_q <= '0;
    end else if (state_q == ST_SCAN) begin
      cnt_q <= cnt_q + IDX_W'(1);
    end
  end

  // Free-space table with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  pfa_fit_unit u_fit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (fit_ctl),
    .policy_i (policy_q),
    .req_i    (amount_q),
    .entry_i  (rd_data_q),
    .stat_o   (fit_stat)
  );

  // Result of the item in flight.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      res_placed_q <= 1'b0;
      res_number_q <= '0;
      res_free_q   <= (cmd_i == CMD_LOAD && slot_ok) ? 16'(SIZE_BITS'(amount_i)) : '0;
      amount_q     <= amount_i;
      fin_q        <= final_request_i;
    end else if (state_q == ST_READ) begin
      res_free_q <= 16'(rd_data_q);
    end else if (state_q == ST_UPDATE && fit_stat.found) begin
      res_placed_q <= 1'b1;
      res_number_q <= 5'(fit_stat.pick) + 5'd1;
      res_free_q   <= 16'(mem_wdata);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_placed_q <= res_placed_q;
      out_number_q <= res_number_q;
      out_free_q   <= res_free_q;
      out_fin_q    <= fin_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign placed_o      = out_placed_q;
  assign slot_number_o = out_number_q;
  assign free_left_o   = out_free_q;
  assign batch_done_o  = out_fin_q;

endmodule

// ===== design/pfa_checker.sv =====
`include "partition_fit_allocator_top_assert.svh"

module pfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        placed_o,
  input logic [4:0]  slot_number_o
);

  // The block is busy in the cycle after it takes an item.
  `PFA_ASSERT_NEXT(busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A placed allocation always names a partition.
  `PFA_ASSERT_IMPL(placed_has_slot, clk_i, rst_ni, out_valid_o && placed_o, slot_number_o != 5'd0)

  // A beat without a placement never names a partition.
  `PFA_ASSERT_IMPL(unplaced_no_slot, clk_i, rst_ni, out_valid_o && !placed_o, slot_number_o == 5'd0)

  // A stalled result beat stays offered.
  `PFA_ASSERT_NEXT(out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

endmodule

bind partition_fit_allocator_top pfa_checker u_pfa_checker (.*);
